// ===== rtl/tpn_pkg.sv =====
// Shared types, widths and constants for the tuner pitch-to-note core.
// No dependencies; every module of the block imports this package.
package tpn_pkg;

    // Fixed-point precision of the log2 result and bar display size
    localparam int LOG_FB       = 16;
    localparam int LED_SEGMENTS = 11;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int REF_W      = 18;
    localparam int GAIN_W     = 9;
    localparam int SNAP_W     = 15;
    localparam int HOLD_W     = 8;
    localparam int WIN_W      = 14;

    // Payload and state widths
    localparam int HZ_W        = 24;
    localparam int CENTS_W     = 16;
    localparam int CENTS_OUT_W = 15;
    localparam int NOTE_W      = 9;
    localparam int IDLE_W      = 8;
    localparam int IDX_W       = 4;
    localparam int OCT_W       = 5;
    localparam int SEG_OUT_W   = 4;

    // Datapath widths
    localparam int NORM_W     = 31;             // mantissa Q1.30
    localparam int M_FRAC     = 30;
    localparam int LZ_W       = 5;
    localparam int NORM_STEPS = 5;              // shifts of 16, 8, 4, 2, 1
    localparam int LOG_W      = LOG_FB + LZ_W;
    localparam int MIDI_W     = LOG_FB + 11;
    localparam int FRAC_W     = LOG_FB + 2;
    localparam int DIFF_W     = CENTS_W + 1;
    localparam int SM_W       = CENTS_W + 4;
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int CNT_W      = $clog2(LOG_FB + 1);
    localparam int SEG_W      = $clog2(LED_SEGMENTS + 1);

    // Musical constants
    localparam int A4_NOTE    = 69;
    localparam int SEMIS      = 12;
    localparam int CENTS_MAX  = 12800;          // 50 cents in Q8
    localparam int CENTS_SPAN = 25600;          // 100 cents in Q8
    localparam int LED_CLAMP  = 49 * 256;
    localparam int GAIN_SH    = 8;
    localparam int NOTE_MIN   = -256;
    localparam int NOTE_MAX   = 255;
    localparam int OCT_MIN    = -16;
    localparam int OCT_MAX    = 15;
    localparam int DIV12_MUL  = 683;            // 683 / 2^13 ~ 1/12, exact for |n| <= 256
    localparam int DIV12_SH   = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REFERENCE_PITCH = 3'd0,
        CFG_SMOOTH_GAIN     = 3'd1,
        CFG_SNAP_THRESHOLD  = 3'd2,
        CFG_HOLD_TICKS      = 3'd3,
        CFG_IN_TUNE_WINDOW  = 3'd4
    } tpn_cfg_idx_t;

    typedef enum logic {
        CMD_READING = 1'b0,
        CMD_TICK    = 1'b1
    } tpn_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM_H,
        ST_LOG_H,
        ST_NORM_R,
        ST_LOG_R,
        ST_MIDI,
        ST_ROUND,
        ST_FRAC,
        ST_TMUL,
        ST_TARGET,
        ST_DIFF,
        ST_GAIN,
        ST_SMOOTH,
        ST_EMIT
    } tpn_state_t;

    typedef struct packed {
        logic [REF_W-1:0]  reference_pitch;
        logic [GAIN_W-1:0] smooth_gain;
        logic [SNAP_W-1:0] snap_threshold;
        logic [HOLD_W-1:0] hold_ticks;
        logic [WIN_W-1:0]  in_tune_window;
    } tpn_cfg_t;

    localparam tpn_cfg_t CFG_RESET = '{
        reference_pitch: 18'd112640,
        smooth_gain:     9'd90,
        snap_threshold:  15'd6400,
        hold_ticks:      8'd75,
        in_tune_window:  14'd768
    };

    // Display state handed from the core to the output stage
    typedef struct packed {
        logic               active;
        logic [NOTE_W-1:0]  note;       // two's complement
        logic [CENTS_W-1:0] cents;      // two's complement, Q8
    } tpn_disp_t;

endpackage

// ===== rtl/tpn_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on tpn_pkg for operand and product widths.
module tpn_mul (
    input  logic                              clk,
    input  logic signed [tpn_pkg::MUL_W-1:0]  a,
    input  logic signed [tpn_pkg::MUL_W-1:0]  b,
    output logic signed [tpn_pkg::PROD_W-1:0] p_reg
);
    import tpn_pkg::*;

    logic signed [PROD_W-1:0] p_next;

    assign p_next = PROD_W'(a) * PROD_W'(b);

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

endmodule

// ===== rtl/tpn_core.sv =====
// Sequencer and datapath: normalize, iterative log2, note rounding and cents smoothing.
// Depends on tpn_pkg; instantiates tpn_mul as the one shared multiplier.
module tpn_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tpn_pkg::tpn_cfg_t           cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        cmd,
    input  logic [tpn_pkg::HZ_W-1:0]    pitch_hz,
    output logic                        emit_valid,
    input  logic                        emit_ready,
    output tpn_pkg::tpn_disp_t          disp
);
    import tpn_pkg::*;

    localparam logic signed [MIDI_W-1:0] MIDI_HALF = MIDI_W'(1 << (LOG_FB - 1));
    localparam logic signed [MIDI_W-1:0] MIDI_A4   = MIDI_W'(A4_NOTE) <<< LOG_FB;
    localparam logic signed [MIDI_W-1:0] NOTE_LO_M = MIDI_W'(NOTE_MIN);
    localparam logic signed [MIDI_W-1:0] NOTE_HI_M = MIDI_W'(NOTE_MAX);
    localparam logic signed [MIDI_W-1:0] FRAC_HI_M = MIDI_W'(1) <<< LOG_FB;
    localparam logic signed [MIDI_W-1:0] FRAC_LO_M = -FRAC_HI_M;
    localparam logic signed [PROD_W-1:0] PROD_HALF_F = PROD_W'(1) <<< (LOG_FB - 1);
    localparam logic signed [PROD_W-1:0] PROD_HALF_G = PROD_W'(1) <<< (GAIN_SH - 1);
    localparam logic signed [PROD_W-1:0] CENTS_HI_P = PROD_W'(CENTS_MAX);
    localparam logic signed [PROD_W-1:0] CENTS_LO_P = -CENTS_HI_P;
    localparam logic signed [SM_W-1:0]   CENTS_HI_S = SM_W'(CENTS_MAX);
    localparam logic signed [SM_W-1:0]   CENTS_LO_S = -CENTS_HI_S;

    tpn_state_t state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [NORM_W-1:0]         norm_reg, norm_next;
    logic [LZ_W-1:0]           lz_reg, lz_next;
    logic [LOG_FB-1:0]         bits_reg, bits_next;
    logic [LOG_W-1:0]          lh_reg, lh_next;
    logic signed [MIDI_W-1:0]  midi_reg, midi_next;
    logic signed [NOTE_W-1:0]  nearest_reg, nearest_next;
    logic signed [FRAC_W-1:0]  frac_reg, frac_next;
    logic signed [CENTS_W-1:0] target_reg, target_next;
    logic signed [DIFF_W-1:0]  diff_reg, diff_next;
    logic                      snap_reg, snap_next;
    logic signed [CENTS_W-1:0] smoothed_reg, smoothed_next;
    logic                      active_reg, active_next;
    logic [IDLE_W-1:0]         idle_reg, idle_next;
    logic signed [NOTE_W-1:0]  note_reg, note_next;

    logic                      accept;
    logic                      log_state;
    logic                      norm_state;
    logic [LZ_W-1:0]           norm_sh;
    logic [LZ_W:0]             norm_rs;
    logic                      norm_top_zero;
    logic [MUL_W-1:0]          sq_q;
    logic                      sq_bit;
    logic [NORM_W-1:0]         sq_m;
    logic [LZ_W-1:0]           log_exp;
    logic [LOG_W-1:0]          log_r_val;
    logic signed [LOG_W:0]     log_d;
    logic signed [MIDI_W-1:0]  d_ext;
    logic signed [MIDI_W-1:0]  midi_neg;
    logic signed [MIDI_W-1:0]  midi_sum;
    logic signed [MIDI_W-1:0]  midi_rnd;
    logic signed [MIDI_W-1:0]  frac_full;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  prod_neg;
    logic signed [PROD_W-1:0]  t_rnd;
    logic signed [PROD_W-1:0]  g_rnd;
    logic signed [SM_W-1:0]    sm_sum;
    logic [DIFF_W-1:0]         adiff;
    logic [IDLE_W-1:0]         idle_inc;
    logic [REF_W-1:0]          ref_val;
    logic signed [MUL_W-1:0]   mul_a, mul_b;

    tpn_mul u_mul (
        .clk   (clk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (prod)
    );

    assign accept     = in_valid && in_ready;
    assign log_state  = (state_reg == ST_LOG_H) || (state_reg == ST_LOG_R);
    assign norm_state = (state_reg == ST_NORM_H) || (state_reg == ST_NORM_R);

    // Binary-step normalize: shift by 16, 8, 4, 2, 1 while the top bits are clear
    assign norm_sh       = LZ_W'(5'd16 >> cnt_reg);
    assign norm_rs       = (LZ_W + 1)'(NORM_W) - {1'b0, norm_sh};
    assign norm_top_zero = ((norm_reg >> norm_rs) == '0);

    // Squaring step: Q1.30 square, pull out one fraction bit
    assign sq_q   = prod[M_FRAC +: MUL_W];
    assign sq_bit = sq_q[MUL_W-1];
    assign sq_m   = sq_bit ? sq_q[MUL_W-1:1] : sq_q[MUL_W-2:0];

    assign log_exp   = LZ_W'(M_FRAC) - lz_reg;
    assign log_r_val = {log_exp, bits_reg};
    assign log_d     = $signed({1'b0, lh_reg}) - $signed({1'b0, log_r_val});
    assign d_ext     = MIDI_W'(log_d);

    assign midi_neg  = $signed({{(MIDI_W-1){1'b0}}, midi_reg[MIDI_W-1]});
    assign midi_sum  = midi_reg + MIDI_HALF - midi_neg;
    assign midi_rnd  = midi_sum >>> LOG_FB;
    assign frac_full = midi_reg - (MIDI_W'(nearest_reg) <<< LOG_FB);

    // Half-away-from-zero rounding: (p + half - sign) >>> shift
    assign prod_neg = $signed({{(PROD_W-1){1'b0}}, prod[PROD_W-1]});
    assign t_rnd    = (prod + PROD_HALF_F - prod_neg) >>> LOG_FB;
    assign g_rnd    = (prod + PROD_HALF_G - prod_neg) >>> GAIN_SH;
    assign sm_sum   = SM_W'(smoothed_reg) + SM_W'(g_rnd);

    assign adiff    = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
    assign idle_inc = (idle_reg != '1) ? idle_reg + 1'b1 : idle_reg;
    assign ref_val  = (cfg.reference_pitch == '0) ? REF_W'(1) : cfg.reference_pitch;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_READING && pitch_hz != '0)
                        state_next = ST_NORM_H;
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_NORM_H:
            begin
                if (cnt_reg == CNT_W'(NORM_STEPS - 1))
                    state_next = ST_LOG_H;
            end
            ST_LOG_H:
            begin
                if (cnt_reg == CNT_W'(LOG_FB))
                    state_next = ST_NORM_R;
            end
            ST_NORM_R:
            begin
                if (cnt_reg == CNT_W'(NORM_STEPS - 1))
                    state_next = ST_LOG_R;
            end
            ST_LOG_R:
            begin
                if (cnt_reg == CNT_W'(LOG_FB))
                    state_next = ST_MIDI;
            end
            ST_MIDI:   state_next = ST_ROUND;
            ST_ROUND:  state_next = ST_FRAC;
            ST_FRAC:   state_next = ST_TMUL;
            ST_TMUL:   state_next = ST_TARGET;
            ST_TARGET: state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_GAIN;
            ST_GAIN:   state_next = ST_SMOOTH;
            ST_SMOOTH: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (emit_ready)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs and multiplier operand select
    always_comb
    begin
        in_ready   = 1'b0;
        emit_valid = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_LOG_H, ST_LOG_R:
            begin
                if (cnt_reg == '0)
                begin
                    mul_a = $signed({1'b0, norm_reg});
                    mul_b = $signed({1'b0, norm_reg});
                end
                else
                begin
                    mul_a = $signed({1'b0, sq_m});
                    mul_b = $signed({1'b0, sq_m});
                end
            end
            ST_TMUL:
            begin
                mul_a = MUL_W'(frac_reg);
                mul_b = MUL_W'(CENTS_SPAN);
            end
            ST_GAIN:
            begin
                mul_a = MUL_W'(diff_reg);
                mul_b = $signed(MUL_W'(cfg.smooth_gain));
            end
            ST_EMIT: emit_valid = 1'b1;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        cnt_next      = cnt_reg;
        norm_next     = norm_reg;
        lz_next       = lz_reg;
        bits_next     = bits_reg;
        lh_next       = lh_reg;
        midi_next     = midi_reg;
        nearest_next  = nearest_reg;
        frac_next     = frac_reg;
        target_next   = target_reg;
        diff_next     = diff_reg;
        snap_next     = snap_reg;
        smoothed_next = smoothed_reg;
        active_next   = active_reg;
        idle_next     = idle_reg;
        note_next     = note_reg;

        if (state_reg == ST_IDLE && accept)
        begin
            cnt_next  = '0;
            lz_next   = '0;
            norm_next = NORM_W'(pitch_hz);
            if (cmd == CMD_TICK)
            begin
                idle_next = idle_inc;
                if (idle_inc > cfg.hold_ticks)
                    active_next = 1'b0;
            end
        end

        if (norm_state)
        begin
            if (norm_top_zero)
            begin
                norm_next = norm_reg << norm_sh;
                lz_next   = lz_reg + norm_sh;
            end
            cnt_next = (cnt_reg == CNT_W'(NORM_STEPS - 1)) ? '0 : cnt_reg + 1'b1;
        end

        if (log_state)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg != '0)
                bits_next = {bits_reg[LOG_FB-2:0], sq_bit};
            if (cnt_reg == CNT_W'(LOG_FB))
            begin
                cnt_next = '0;
                if (state_reg == ST_LOG_H)
                begin
                    lh_next   = {log_exp, bits_next};
                    lz_next   = '0;
                    norm_next = NORM_W'(ref_val);
                end
            end
        end

        case (state_reg)
            ST_MIDI:
                midi_next = MIDI_A4 + (d_ext <<< 3) + (d_ext <<< 2);
            ST_ROUND:
            begin
                if (midi_rnd < NOTE_LO_M)
                    nearest_next = NOTE_W'(NOTE_LO_M);
                else if (midi_rnd > NOTE_HI_M)
                    nearest_next = NOTE_W'(NOTE_HI_M);
                else
                    nearest_next = NOTE_W'(midi_rnd);
            end
            ST_FRAC:
            begin
                if (frac_full < FRAC_LO_M)
                    frac_next = FRAC_W'(FRAC_LO_M);
                else if (frac_full > FRAC_HI_M)
                    frac_next = FRAC_W'(FRAC_HI_M);
                else
                    frac_next = FRAC_W'(frac_full);
            end
            ST_TARGET:
            begin
                if (t_rnd < CENTS_LO_P)
                    target_next = CENTS_W'(CENTS_LO_P);
                else if (t_rnd > CENTS_HI_P)
                    target_next = CENTS_W'(CENTS_HI_P);
                else
                    target_next = CENTS_W'(t_rnd);
            end
            ST_DIFF:
                diff_next = DIFF_W'(target_reg) - DIFF_W'(smoothed_reg);
            ST_GAIN:
                snap_next = adiff > DIFF_W'(cfg.snap_threshold);
            ST_SMOOTH:
            begin
                if (snap_reg)
                    smoothed_next = target_reg;
                else if (sm_sum < CENTS_LO_S)
                    smoothed_next = CENTS_W'(CENTS_LO_S);
                else if (sm_sum > CENTS_HI_S)
                    smoothed_next = CENTS_W'(CENTS_HI_S);
                else
                    smoothed_next = CENTS_W'(sm_sum);
                note_next   = nearest_reg;
                idle_next   = '0;
                active_next = 1'b1;
            end
            default:
            begin
                midi_next = midi_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            smoothed_reg <= '0;
            active_reg   <= 1'b0;
            idle_reg     <= '0;
            note_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            smoothed_reg <= smoothed_next;
            active_reg   <= active_next;
            idle_reg     <= idle_next;
            note_reg     <= note_next;
        end
    end

    always_ff @(posedge clk)
    begin
        norm_reg    <= norm_next;
        lz_reg      <= lz_next;
        bits_reg    <= bits_next;
        lh_reg      <= lh_next;
        midi_reg    <= midi_next;
        nearest_reg <= nearest_next;
        frac_reg    <= frac_next;
        target_reg  <= target_next;
        diff_reg    <= diff_next;
        snap_reg    <= snap_next;
    end

    assign disp.active = active_reg;
    assign disp.note   = note_reg;
    assign disp.cents  = smoothed_reg;

    // Shown cents never leave the half-semitone range
    a_cents_range: assert property (@(posedge clk) disable iff (!rst_n)
        (smoothed_reg <= CENTS_W'(CENTS_MAX)) && (smoothed_reg >= -CENTS_W'(CENTS_MAX)))
        else $error("smoothed cents out of range");

    // Five normalize steps always land the leading one on the top bit
    a_norm_lead: assert property (@(posedge clk) disable iff (!rst_n)
        (norm_state && cnt_reg == CNT_W'(NORM_STEPS - 1)) |=> norm_reg[NORM_W-1])
        else $error("mantissa not normalized");

    // A normalized mantissa squares to at least one in Q1.30
    a_square_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (log_state && cnt_reg != '0) |-> (sq_q[MUL_W-1:MUL_W-2] != 2'b00))
        else $error("square fell below one");

    // A finished reading shows as active with a cleared idle count
    a_reading_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SMOOTH) |=> (active_reg && idle_reg == '0 && emit_valid))
        else $error("reading not committed");

endmodule

// ===== rtl/tpn_display.sv =====
// Output stage: turns the display state into note, octave, cents and bar segment words.
// Depends on tpn_pkg; holds the output register and its valid/ready handshake.
module tpn_display (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [tpn_pkg::WIN_W-1:0]         in_tune_window,
    input  logic                              emit_valid,
    output logic                              emit_ready,
    input  tpn_pkg::tpn_disp_t                disp,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              active,
    output logic [tpn_pkg::IDX_W-1:0]         note_index,
    output logic signed [tpn_pkg::OCT_W-1:0]  octave,
    output logic signed [tpn_pkg::CENTS_OUT_W-1:0] cents,
    output logic                              in_tune,
    output logic [tpn_pkg::SEG_OUT_W-1:0]     led_segment
);
    import tpn_pkg::*;

    localparam int NM_W = NOTE_W + 1;
    localparam int QP_W = 2 * NM_W;
    localparam int QS_W = 6;
    localparam int X_W  = 15;
    localparam int PX_W = X_W + SEG_W;
    localparam logic signed [CENTS_W-1:0] LED_HI = CENTS_W'(LED_CLAMP);
    localparam logic signed [CENTS_W-1:0] LED_LO = -LED_HI;
    localparam logic signed [QS_W-1:0]    OCT_HI = QS_W'(OCT_MAX);
    localparam logic signed [QS_W-1:0]    OCT_LO = QS_W'(OCT_MIN);

    logic                        out_valid_reg, out_valid_next;
    logic                        active_reg, active_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [OCT_W-1:0]            oct_reg, oct_next;
    logic [CENTS_OUT_W-1:0]      cents_reg, cents_next;
    logic                        tune_reg, tune_next;
    logic [SEG_OUT_W-1:0]        seg_reg, seg_next;

    logic                        load;
    logic                        n_neg;
    logic [NM_W-1:0]             n_ext;
    logic [NM_W-1:0]             n_mag;
    logic [QP_W-1:0]             q_prod;
    logic [LZ_W-1:0]             q;
    logic [IDX_W-1:0]            rem;
    logic [IDX_W-1:0]            idx_val;
    logic signed [QS_W-1:0]      q_s;
    logic signed [QS_W-1:0]      oct_full;
    logic [OCT_W-1:0]            oct_val;
    logic signed [CENTS_W-1:0]   c;
    logic [CENTS_W-1:0]          abs_c;
    logic                        tune_val;
    logic signed [CENTS_W-1:0]   cc;
    logic [CENTS_W-1:0]          x_full;
    logic [PX_W-1:0]             px;
    logic [SEG_W-1:0]            seg_cnt;
    logic [SEG_OUT_W-1:0]        seg_val;

    assign emit_ready = !out_valid_reg || out_ready;
    assign load       = emit_valid && emit_ready;

    // Note class and octave: truncating divide by 12 through a reciprocal
    assign n_neg   = disp.note[NOTE_W-1];
    assign n_ext   = {disp.note[NOTE_W-1], disp.note};
    assign n_mag   = n_neg ? (NM_W'(0) - n_ext) : n_ext;
    assign q_prod  = QP_W'(n_mag) * QP_W'(DIV12_MUL);
    assign q       = LZ_W'(q_prod >> DIV12_SH);
    assign rem     = IDX_W'(n_mag - NM_W'(q) * NM_W'(SEMIS));
    assign idx_val = (n_neg && rem != '0) ? IDX_W'(SEMIS) - rem : rem;
    assign q_s     = n_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    assign oct_full = q_s - QS_W'(1);
    assign oct_val = (oct_full > OCT_HI) ? OCT_W'(OCT_HI) :
                     (oct_full < OCT_LO) ? OCT_W'(OCT_LO) : OCT_W'(oct_full);

    assign c        = $signed(disp.cents);
    assign abs_c    = c[CENTS_W-1] ? CENTS_W'(-c) : CENTS_W'(c);
    assign tune_val = abs_c <= CENTS_W'(in_tune_window);

    // Bar position: count segment boundaries at or below the scaled offset
    assign cc     = (c > LED_HI) ? LED_HI : (c < LED_LO) ? LED_LO : c;
    assign x_full = CENTS_W'(cc + CENTS_W'(CENTS_MAX));
    assign px     = PX_W'(x_full[X_W-1:0]) * PX_W'(LED_SEGMENTS);

    always_comb
    begin
        seg_cnt = '0;
        for (int k = 1; k < LED_SEGMENTS; k++)
        begin
            if (px >= PX_W'(k * CENTS_SPAN))
                seg_cnt = seg_cnt + 1'b1;
        end
    end

    assign seg_val = tune_val ? SEG_OUT_W'(LED_SEGMENTS / 2) : SEG_OUT_W'(seg_cnt);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        active_next    = active_reg;
        idx_next       = idx_reg;
        oct_next       = oct_reg;
        cents_next     = cents_reg;
        tune_next      = tune_reg;
        seg_next       = seg_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            active_next    = disp.active;
            if (disp.active)
            begin
                idx_next   = idx_val;
                oct_next   = oct_val;
                cents_next = disp.cents[CENTS_OUT_W-1:0];
                tune_next  = tune_val;
                seg_next   = seg_val;
            end
            else
            begin
                idx_next   = '0;
                oct_next   = '0;
                cents_next = '0;
                tune_next  = 1'b0;
                seg_next   = SEG_OUT_W'(LED_SEGMENTS);
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        active_reg <= active_next;
        idx_reg    <= idx_next;
        oct_reg    <= oct_next;
        cents_reg  <= cents_next;
        tune_reg   <= tune_next;
        seg_reg    <= seg_next;
    end

    assign out_valid   = out_valid_reg;
    assign active      = active_reg;
    assign note_index  = idx_reg;
    assign octave      = $signed(oct_reg);
    assign cents       = $signed(cents_reg);
    assign in_tune     = tune_reg;
    assign led_segment = seg_reg;

endmodule

// ===== rtl/tuner_pitch_to_note_cents_top.sv =====
// Top level of the tuner pitch-to-note core: configuration registers and instances.
// Depends on tpn_pkg, tpn_core (with tpn_mul) and tpn_display.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word: cmd and pitch_hz.
//   cmd = reading with nonzero pitch_hz (unsigned Q16.8 Hz) updates note and
//   smoothed cents; a zero pitch leaves the display as is. cmd = tick ages the
//   display and drops active once the idle count passes hold_ticks.
//   Every input word yields exactly one output word on out_valid/out_ready.
//   A reading runs the shared 32x32 multiplier through the log2 squaring loop
//   one fraction bit per cycle, first for the pitch and then for the
//   reference, then rounds the note and smooths the cents. Ticks and zero
//   readings skip the log2 datapath and go straight to the emit step.
//   One word is in flight at a time: a new word is taken only once the
//   last one has left the emit step.
//   in_ready is high only while the sequencer idles; a finished output word
//   waits in the output register, so a stalled receiver holds the sequencer
//   in its emit step and new input waits until that word moves.
//   Reset (rst_n low, async) clears the display state, loads the default
//   register values (440 Hz reference) and empties the output register.
//   Config writes (cfg_we/cfg_index/cfg_wdata) are registered; write only
//   while idle. Unknown indexes are ignored.
module tuner_pitch_to_note_cents_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [tpn_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [tpn_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   cmd,
    input  logic [tpn_pkg::HZ_W-1:0]               pitch_hz,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   active,
    output logic [tpn_pkg::IDX_W-1:0]              note_index,
    output logic signed [tpn_pkg::OCT_W-1:0]       octave,
    output logic signed [tpn_pkg::CENTS_OUT_W-1:0] cents,
    output logic                                   in_tune,
    output logic [tpn_pkg::SEG_OUT_W-1:0]          led_segment
);
    import tpn_pkg::*;

    tpn_cfg_t  cfg_reg, cfg_next;
    tpn_disp_t disp;
    logic      emit_valid;
    logic      emit_ready;

    // Register file: take each write straight into its field
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_REFERENCE_PITCH: cfg_next.reference_pitch = cfg_wdata[REF_W-1:0];
                CFG_SMOOTH_GAIN:     cfg_next.smooth_gain     = cfg_wdata[GAIN_W-1:0];
                CFG_SNAP_THRESHOLD:  cfg_next.snap_threshold  = cfg_wdata[SNAP_W-1:0];
                CFG_HOLD_TICKS:      cfg_next.hold_ticks      = cfg_wdata[HOLD_W-1:0];
                CFG_IN_TUNE_WINDOW:  cfg_next.in_tune_window  = cfg_wdata[WIN_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    // Sequencer, log2 datapath and state
    tpn_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .pitch_hz   (pitch_hz),
        .emit_valid (emit_valid),
        .emit_ready (emit_ready),
        .disp       (disp)
    );

    // Formatting and the output register
    tpn_display u_display (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_tune_window (cfg_reg.in_tune_window),
        .emit_valid     (emit_valid),
        .emit_ready     (emit_ready),
        .disp           (disp),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .active         (active),
        .note_index     (note_index),
        .octave         (octave),
        .cents          (cents),
        .in_tune        (in_tune),
        .led_segment    (led_segment)
    );

endmodule

// ===== tb/sv/tb_tuner_pitch_to_note_cents_top.sv =====
// Self-checking testbench for tuner_pitch_to_note_cents_top: directed table, then random phases.
// Depends on tpn_pkg and the RTL of the block; predicts every display word in fixed point.
`timescale 1ns / 1ps

module tb_tuner_pitch_to_note_cents_top;
    import tpn_pkg::*;

    // Run limits and pacing
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RAND_PER_PHASE = 38;
    localparam int NUM_PHASES     = 6;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_CYCLES     = 64;     // wait at the end for stray words
    localparam int TICK_FLOOD     = 260;    // enough ticks to saturate the idle count
    localparam longint FIX_ONE    = longint'(1) << LOG_FB;

    // One display word as the block presents it
    typedef struct packed {
        logic                   active;
        logic [IDX_W-1:0]       note_index;
        logic [OCT_W-1:0]       octave;
        logic [CENTS_OUT_W-1:0] cents;
        logic                   in_tune;
        logic [SEG_OUT_W-1:0]   led_segment;
    } disp_word_t;

    // Blank display: nothing lit
    localparam disp_word_t DARK = '{1'b0, 4'd0, 5'd0, 15'd0, 1'b0, SEG_OUT_W'(LED_SEGMENTS)};
    // A at 440, 880 and 220 Hz under the default reference: exact octaves, zero cents
    localparam disp_word_t A4_SHOWN = '{1'b1, 4'd9, 5'd4, 15'd0, 1'b1,
                                        SEG_OUT_W'(LED_SEGMENTS / 2)};
    localparam disp_word_t A5_SHOWN = '{1'b1, 4'd9, 5'd5, 15'd0, 1'b1,
                                        SEG_OUT_W'(LED_SEGMENTS / 2)};
    localparam disp_word_t A3_SHOWN = '{1'b1, 4'd9, 5'd3, 15'd0, 1'b1,
                                        SEG_OUT_W'(LED_SEGMENTS / 2)};

    typedef struct {
        tpn_cmd_t        c;
        logic [HZ_W-1:0] hz;
        bit              typed;
        disp_word_t      want;
    } dir_row_t;

    localparam int DIR_N = 21;

    // Directed table: typed expectations only where they are obvious, else predicted
    dir_row_t dir_rows [DIR_N] = '{
        '{CMD_TICK,    24'd0,       1'b1, DARK},      // tick right after reset
        '{CMD_READING, 24'd0,       1'b1, DARK},      // no reading while dark
        '{CMD_READING, 24'd112640,  1'b1, A4_SHOWN},  // exactly the reference
        '{CMD_READING, 24'd225280,  1'b1, A5_SHOWN},  // one octave up
        '{CMD_READING, 24'd56320,   1'b1, A3_SHOWN},  // one octave down
        '{CMD_READING, 24'd0,       1'b1, A3_SHOWN},  // no reading: display held
        '{CMD_TICK,    24'hFFFFFF,  1'b1, A3_SHOWN},  // one tick stays inside hold
        '{CMD_READING, 24'd115272,  1'b0, DARK},      // +40 cents: snap to target
        '{CMD_READING, 24'd114609,  1'b0, DARK},      // +30 cents: smoothing step
        '{CMD_READING, 24'd115940,  1'b0, DARK},      // near +50 cents: rounding edge
        '{CMD_READING, 24'd109432,  1'b0, DARK},      // near -50 cents
        '{CMD_READING, 24'd113293,  1'b0, DARK},
        '{CMD_READING, 24'hFFFFFF,  1'b0, DARK},      // highest pitch code
        '{CMD_READING, 24'd1,       1'b0, DARK},      // lowest pitch code, negative octave
        '{CMD_READING, 24'h800000,  1'b0, DARK},
        '{CMD_READING, 24'h555555,  1'b0, DARK},
        '{CMD_READING, 24'hAAAAAA,  1'b0, DARK},
        '{CMD_READING, 24'd256,     1'b0, DARK},      // 1 Hz
        '{CMD_READING, 24'd112641,  1'b0, DARK},
        '{CMD_TICK,    24'd0,       1'b0, DARK},
        '{CMD_READING, 24'd112640,  1'b0, DARK}
    };

    // Block ports
    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic                     cmd       = 1'b0;
    logic [HZ_W-1:0]          pitch_hz  = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     active;
    logic [IDX_W-1:0]         note_index;
    logic signed [OCT_W-1:0]  octave;
    logic signed [CENTS_OUT_W-1:0] cents;
    logic                     in_tune;
    logic [SEG_OUT_W-1:0]     led_segment;

    // Typed expectation travelling with the word on the input channel
    logic       row_typed = 1'b0;
    disp_word_t row_want  = '0;

    // Register copies held by the predictor
    logic [REF_W-1:0]  ref_cfg   = CFG_RESET.reference_pitch;
    logic [GAIN_W-1:0] gain_cfg  = CFG_RESET.smooth_gain;
    logic [SNAP_W-1:0] snap_cfg  = CFG_RESET.snap_threshold;
    logic [HOLD_W-1:0] hold_cfg  = CFG_RESET.hold_ticks;
    logic [WIN_W-1:0]  win_cfg   = CFG_RESET.in_tune_window;

    // Display state held by the predictor
    logic signed [CENTS_W-1:0] cur_cents  = '0;
    logic                      shown      = 1'b0;
    logic [IDLE_W-1:0]         idle_ticks = '0;
    logic signed [NOTE_W-1:0]  last_note  = '0;

    disp_word_t  due_displays [$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    int          holdoff_req    = 0;
    int          holdoff_done   = 0;
    int          stall_left     = 0;
    logic [HZ_W-1:0] last_hz    = 24'd112640;

    tuner_pitch_to_note_cents_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .pitch_hz    (pitch_hz),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .active      (active),
        .note_index  (note_index),
        .octave      (octave),
        .cents       (cents),
        .in_tune     (in_tune),
        .led_segment (led_segment)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Fixed-point predictor
    // ---------------------------------------------------------------

    // log2 with LOG_FB fraction bits: normalize to Q1.30, then square once per bit
    function automatic bit [63:0] log2_fixed(input bit [31:0] x);
        bit [31:0] v;
        bit [31:0] t;
        bit [63:0] m;
        bit [63:0] r;
        int        e;
        int        i;
        v = (x == 0) ? 32'd1 : x;
        t = v;
        e = 0;
        while (t > 1)
        begin
            t = t >> 1;
            e++;
        end
        m = 64'(v) << (30 - e);
        r = 64'(e) << LOG_FB;
        for (i = LOG_FB - 1; i >= 0; i--)
        begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000)
            begin
                r[i] = 1'b1;
                m = m >> 1;
            end
        end
        return r;
    endfunction

    // Divide by 2^sh, rounding half away from zero
    function automatic longint round_shift(input longint num, input int sh);
        longint half;
        half = longint'(1) << (sh - 1);
        if (num >= 0)
            return (num + half) >>> sh;
        return -((-num + half) >>> sh);
    endfunction

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the display state by one word and return what it shows afterwards
    function automatic disp_word_t tuner_advance(input tpn_cmd_t c, input logic [HZ_W-1:0] hz);
        logic [REF_W-1:0] refv;
        longint d;
        longint midi;
        longint near_note;
        longint frac;
        longint target;
        longint diff;
        longint absdiff;
        int         n;
        int         oct;
        int         cc;
        int         absc;
        int         seg;
        disp_word_t w;
        w = DARK;
        if (c == CMD_READING)
        begin
            if (hz != '0)
            begin
                refv = (ref_cfg == '0) ? REF_W'(1) : ref_cfg;
                d = longint'(log2_fixed(32'(hz))) - longint'(log2_fixed(32'(refv)));
                midi = longint'(A4_NOTE) * FIX_ONE + 12 * d;
                near_note = clamp_to(round_shift(midi, LOG_FB), NOTE_MIN, NOTE_MAX);
                frac = midi - near_note * FIX_ONE;
                target = clamp_to(round_shift(frac * CENTS_SPAN, LOG_FB),
                                  -CENTS_MAX, CENTS_MAX);
                diff = target - longint'(cur_cents);
                absdiff = (diff < 0) ? -diff : diff;
                // Far from the target: jump; close: step by the gain
                if (absdiff > longint'(snap_cfg))
                    cur_cents = CENTS_W'(target);
                else
                    cur_cents = CENTS_W'(clamp_to(longint'(cur_cents) +
                                         round_shift(longint'(gain_cfg) * diff, GAIN_SH),
                                         -CENTS_MAX, CENTS_MAX));
                last_note  = NOTE_W'(near_note);
                idle_ticks = '0;
                shown      = 1'b1;
            end
        end
        else
        begin
            if (idle_ticks != '1)
                idle_ticks++;
            if (idle_ticks > hold_cfg && shown)
                shown = 1'b0;
        end

        if (shown)
        begin
            n    = int'(last_note);
            oct  = int'(clamp_to(n / 12 - 1, OCT_MIN, OCT_MAX));
            cc   = int'(cur_cents);
            absc = (cc < 0) ? -cc : cc;
            w.active     = 1'b1;
            w.note_index = IDX_W'(((n % 12) + 12) % 12);
            w.octave     = OCT_W'(oct);
            w.cents      = cur_cents[CENTS_OUT_W-1:0];
            w.in_tune    = (absc <= int'(win_cfg));
            if (w.in_tune)
                w.led_segment = SEG_OUT_W'(LED_SEGMENTS / 2);
            else
            begin
                seg = (int'(clamp_to(cc, -LED_CLAMP, LED_CLAMP)) + CENTS_MAX) * LED_SEGMENTS
                      / CENTS_SPAN;
                if (seg > LED_SEGMENTS - 1)
                    seg = LED_SEGMENTS - 1;
                w.led_segment = SEG_OUT_W'(seg);
            end
        end
        return w;
    endfunction

    // ---------------------------------------------------------------
    // Checking: predict on input accept, compare on output accept
    // ---------------------------------------------------------------

    task automatic compare_field(input string fname, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, fname, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        disp_word_t exp_w;
        disp_word_t pred_w;
        // Check the output side first so a word can never match its own prediction
        if (rst_n && out_valid && out_ready)
        begin
            if (due_displays.size() == 0)
            begin
                $display("%0t: output word with nothing expected", $time);
                mismatch_count++;
            end
            else
            begin
                exp_w = due_displays.pop_front();
                compare_field("active",      32'(exp_w.active),      32'(active));
                compare_field("note_index",  32'(exp_w.note_index),  32'(note_index));
                compare_field("octave",      32'(exp_w.octave),      32'($unsigned(octave)));
                compare_field("cents",       32'(exp_w.cents),       32'($unsigned(cents)));
                compare_field("in_tune",     32'(exp_w.in_tune),     32'(in_tune));
                compare_field("led_segment", 32'(exp_w.led_segment), 32'(led_segment));
            end
        end
        // Always run the predictor so its state tracks the block; typed rows override it
        if (rst_n && in_valid && in_ready)
        begin
            pred_w = tuner_advance(tpn_cmd_t'(cmd), pitch_hz);
            due_displays.push_back(row_typed ? row_want : pred_w);
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random back-pressure, plus a long hold-off on request
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (holdoff_req != holdoff_done)
        begin
            // Hold off for a long stretch; the sender keeps offering meanwhile
            holdoff_done <= holdoff_req;
            stall_left   <= HOLDOFF_CYCLES;
            out_ready    <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ---------------------------------------------------------------
    // Sender and configuration helpers
    // ---------------------------------------------------------------

    // Offer one word and hold it until accepted; returns in the accept step
    task automatic send_word(input tpn_cmd_t c, input logic [HZ_W-1:0] hz,
                             input bit typed, input disp_word_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        pitch_hz  <= hz;
        row_typed <= typed;
        row_want  <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (c == CMD_READING && hz != '0)
            last_hz = hz;
    endtask

    // Drop valid and wait for every expected word to come back; step once first so
    // the word accepted in this step is already queued
    task automatic drain_displays();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_displays.size() != 0)
            @(posedge clk);
    endtask

    // Drain, then wait SETTLE_CYCLES for the sequencer to get back to idle
    task automatic settle();
        drain_displays();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input tpn_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_REFERENCE_PITCH: ref_cfg  = val[REF_W-1:0];
            CFG_SMOOTH_GAIN:     gain_cfg = val[GAIN_W-1:0];
            CFG_SNAP_THRESHOLD:  snap_cfg = val[SNAP_W-1:0];
            CFG_HOLD_TICKS:      hold_cfg = val[HOLD_W-1:0];
            CFG_IN_TUNE_WINDOW:  win_cfg  = val[WIN_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Write all five registers for one phase; phases 1..3 are the extremes
    task automatic load_settings(input int phase);
        int rp;
        int gn;
        int sn;
        int hd;
        int wn;
        case (phase)
            0:
            begin
                rp = 112640; gn = 90;  sn = 6400;  hd = 75;  wn = 768;
            end
            1:
            begin
                rp = 25600;  gn = 0;   sn = 0;     hd = 1;   wn = 0;
            end
            2:
            begin
                rp = 256000; gn = 256; sn = 25600; hd = 254; wn = 12800;
            end
            3:
            begin
                // zero reference, overshooting gain, never snap, never go dark
                rp = 0;      gn = 511; sn = 32767; hd = 255; wn = 16383;
            end
            4:
            begin
                rp = $urandom_range(25600, 256000);
                gn = $urandom_range(0, 256);
                sn = $urandom_range(0, 25600);
                hd = 0;
                wn = $urandom_range(0, 12800);
            end
            default:
            begin
                rp = $urandom_range(25600, 262143);
                gn = $urandom_range(0, 256);
                sn = $urandom_range(0, 25600);
                hd = $urandom_range(1, 8);
                wn = $urandom_range(0, 12800);
            end
        endcase
        write_reg(CFG_REFERENCE_PITCH, CFG_DATA_W'(rp));
        write_reg(CFG_SMOOTH_GAIN,     CFG_DATA_W'(gn));
        write_reg(CFG_SNAP_THRESHOLD,  CFG_DATA_W'(sn));
        write_reg(CFG_HOLD_TICKS,      CFG_DATA_W'(hd));
        write_reg(CFG_IN_TUNE_WINDOW,  CFG_DATA_W'(wn));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random traffic: mostly a held note with small jitter, as a real tuner sees it,
    // with fresh notes, dropouts, tick bursts and raw noise mixed in
    task automatic play_random(input int count);
        int              k;
        int              pick;
        int              burst;
        int              tmp;
        logic [HZ_W-1:0] hz;
        k = 0;
        while (k < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                burst = $urandom_range(1, 10);
                repeat (burst) send_word(CMD_TICK, HZ_W'($urandom), 1'b0, DARK);
                k += burst;
            end
            else
            begin
                if (pick < 52)
                begin
                    tmp = int'(last_hz) + int'($urandom_range(0, 800)) - 400;
                    tmp = (tmp < 1) ? 1 : (tmp > 24'hFFFFFF) ? 24'hFFFFFF : tmp;
                    hz  = HZ_W'(tmp);
                end
                else if (pick < 75)
                    hz = HZ_W'($urandom_range(5120, 1280000));      // 20 Hz .. 5 kHz
                else if (pick < 84)
                    hz = '0;
                else if (pick < 95)
                    hz = HZ_W'($urandom);
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       hz = HZ_W'(1);
                        1:       hz = '1;
                        2:       hz = HZ_W'(1) << $urandom_range(0, HZ_W - 1);
                        default: hz = HZ_W'(ref_cfg);
                    endcase
                end
                send_word(CMD_READING, hz, 1'b0, DARK);
                k++;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        int p;
        int r;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under reset settings
        send_idle_pct = 29;
        recv_idle_pct <= 88;
        for (r = 0; r < DIR_N; r++)
            send_word(dir_rows[r].c, dir_rows[r].hz, dir_rows[r].typed, dir_rows[r].want);
        settle();

        // Random phases: receiver idles first, then the sender, then neither
        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p < 2)
            begin
                send_idle_pct = 29;
                recv_idle_pct <= 88;
            end
            else if (p < 4)
            begin
                send_idle_pct = 88;
                recv_idle_pct <= 29;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            load_settings(p);
            if (p == 0)
                holdoff_req <= holdoff_req + 1;     // stall the receiver, keep sending
            play_random(RAND_PER_PHASE / 2);
            if (p == 2)
                drain_displays();                   // pause until every word is back
            play_random(RAND_PER_PHASE - RAND_PER_PHASE / 2);
            if (p == 3)
                repeat (TICK_FLOOD) send_word(CMD_TICK, HZ_W'($urandom), 1'b0, DARK);
            settle();
        end

        // Watch for stray words a while longer
        repeat (END_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: cycle limit reached", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
